FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/ptt_pkg.sv
// Types and constants of the programmable transition table state machine.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int STATE_BITS   = 4;
  localparam int INPUT_LINES  = 16;
  localparam int MESSAGE_BITS = 8;
  localparam int SEL_BITS     = $clog2(INPUT_LINES);
  localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_STEP   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_MODIFY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_APPEND,
    FSM_SCAN,
    FSM_SHIFT,
    FSM_DONE
  } fsm_state_t;

  typedef struct packed {
    logic [STATE_BITS-1:0]   src;
    logic [SEL_BITS-1:0]     sel;
    logic [STATE_BITS-1:0]   dst;
    logic [MESSAGE_BITS-1:0] msg;
  } entry_t;

  typedef struct packed {
    mode_t                   mode;
    logic [STATE_BITS-1:0]   from_state;
    logic [SEL_BITS-1:0]     input_select;
    logic [STATE_BITS-1:0]   to_state;
    logic [MESSAGE_BITS-1:0] message_code;
    logic [INPUT_LINES-1:0]  input_lines;
  } in_t;

  typedef struct packed {
    logic [STATE_BITS-1:0]   present_state;
    logic                    fired;
    logic [MESSAGE_BITS-1:0] fired_message;
    status_t                 status;
  } out_t;

endpackage

FILE: rtl/core/programmable_transition_table_fsm.sv
// Top level of the programmable transition table state machine.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Command channel: drive item and pulse start; the word is taken at an edge
//   with start high and busy low. busy stays high until the result is shown.
//   Result channel: done is high for exactly one cycle with result valid.
//   The receiver cannot hold results off; it must take the word that cycle.
//   Config channel: cfg_data is the initial state; written when cfg_valid and
//   cfg_ready are high. cfg_ready is high only while idle. A write also loads
//   the current state at once.
// Timing
//   One compare unit checks one table entry per cycle, so the ordered scan
//   sets the latency. Step, remove and modify pass idle (accept), then scan
//   the held entries in order until a hit or past the last one, then done
//   (result); remove first moves each later entry down one place in the
//   shift state and then drops the count. Add passes idle, append and done.
//   A new word is taken the cycle after done.
// Reset
//   rst (synchronous) empties the table, sets the current state to 0 and
//   returns the sequencer to idle. Table contents are not cleared.

module programmable_transition_table_fsm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ptt_pkg::in_t                    item,
  output logic                            done,
  output ptt_pkg::out_t                   result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptt_pkg::STATE_BITS-1:0]  cfg_data
);
  import ptt_pkg::*;

  fsm_state_t            state, state_next;
  logic [STATE_BITS-1:0] cur, cur_next;
  logic [CNT_BITS-1:0]   count, count_next;
  logic [CNT_BITS-1:0]   idx, idx_next;
  in_t                   cmd;
  out_t                  res, res_next;
  entry_t                tbl [TABLE_DEPTH];

  // single write port into the table
  logic                  tbl_we;
  logic [IDX_BITS-1:0]   tbl_waddr;
  entry_t                tbl_wdata;

  // shared read and compare unit
  logic [CNT_BITS-1:0]   nxt;
  logic [IDX_BITS-1:0]   rd_addr;
  entry_t                rd;
  logic                  step_hit, key_hit, hit, at_end, accept;

  assign accept = start && (state == FSM_IDLE);
  assign nxt    = idx + CNT_BITS'(1);

  // while shifting, read the entry above the one being written
  assign rd_addr  = (state == FSM_SHIFT) ? nxt[IDX_BITS-1:0] : idx[IDX_BITS-1:0];
  assign rd       = tbl[rd_addr];
  assign step_hit = (rd.src == cur) && cmd.input_lines[rd.sel];
  assign key_hit  = (rd.src == cmd.from_state) && (rd.sel == cmd.input_select);
  assign hit      = (cmd.mode == MODE_STEP) ? step_hit : key_hit;
  assign at_end   = (idx == count);

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = (item.mode == MODE_ADD) ? FSM_APPEND : FSM_SCAN;
        end
      end
      FSM_APPEND: state_next = FSM_DONE;
      FSM_SCAN: begin
        if (at_end) begin
          state_next = FSM_DONE;
        end else if (hit) begin
          state_next = (cmd.mode == MODE_REMOVE) ? FSM_SHIFT : FSM_DONE;
        end
      end
      FSM_SHIFT: begin
        if (nxt >= count) begin
          state_next = FSM_DONE;
        end
      end
      FSM_DONE: state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  // sequencer: datapath control
  always_comb begin
    cur_next   = cur;
    count_next = count;
    idx_next   = idx;
    res_next   = res;
    tbl_we     = 1'b0;
    tbl_waddr  = idx[IDX_BITS-1:0];
    tbl_wdata  = rd;
    unique case (state)
      FSM_IDLE: begin
        idx_next = '0;
        if (cfg_valid) begin
          cur_next = cfg_data;
        end
        if (accept) begin
          res_next.present_state = cur;
          res_next.fired         = 1'b0;
          res_next.fired_message = '0;
          res_next.status        = STAT_OK;
        end
      end
      FSM_APPEND: begin
        if (count == CNT_BITS'(TABLE_DEPTH)) begin
          res_next.status = STAT_FULL;
        end else begin
          tbl_we         = 1'b1;
          tbl_waddr      = count[IDX_BITS-1:0];
          tbl_wdata.src  = cmd.from_state;
          tbl_wdata.sel  = cmd.input_select;
          tbl_wdata.dst  = cmd.to_state;
          tbl_wdata.msg  = cmd.message_code;
          count_next     = count + CNT_BITS'(1);
        end
      end
      FSM_SCAN: begin
        if (at_end) begin
          if (cmd.mode != MODE_STEP) begin
            res_next.status = STAT_NOT_FOUND;
          end
        end else if (hit) begin
          unique case (cmd.mode)
            MODE_STEP: begin
              cur_next               = rd.dst;
              res_next.present_state = rd.dst;
              res_next.fired         = 1'b1;
              res_next.fired_message = rd.msg;
            end
            MODE_MODIFY: begin
              tbl_we        = 1'b1;
              tbl_wdata.dst = cmd.to_state;
              tbl_wdata.msg = cmd.message_code;
            end
            MODE_REMOVE: ;  // entries move down in the shift state
            MODE_ADD:    ;
            default:     ;
          endcase
        end else begin
          idx_next = nxt;
        end
      end
      FSM_SHIFT: begin
        if (nxt < count) begin
          tbl_we   = 1'b1;
          idx_next = nxt;
        end else begin
          count_next = count - CNT_BITS'(1);
        end
      end
      FSM_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      cur   <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept) begin
      cmd <= item;
    end
    if (tbl_we) begin
      tbl[tbl_waddr] <= tbl_wdata;
    end
  end

  assign busy      = (state != FSM_IDLE);
  assign cfg_ready = (state == FSM_IDLE);
  assign done      = (state == FSM_DONE);
  assign result    = res;

  // checks
  `ASSERT_IMPLY(a_count_range, clk, rst, 1'b1, count <= CNT_BITS'(TABLE_DEPTH))
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_IMPLY(a_fired_ok, clk, rst, done && result.fired, result.status == STAT_OK)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

endmodule
